### src/nv21r_pkg.sv
// Shared types and constants of the NV21 frame rotator.
// No dependencies; every other file of the block imports this package.
package nv21r_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 2'd2;

    // Register reset values
    localparam logic [9:0] FRAME_WIDTH_RST  = 10'd640;
    localparam logic [8:0] FRAME_HEIGHT_RST = 9'd480;

    // Rotation codes; other codes pass the frame through
    localparam logic [2:0] ROT_NONE     = 3'd0;
    localparam logic [2:0] ROT_CW90     = 3'd1;
    localparam logic [2:0] ROT_180      = 3'd2;
    localparam logic [2:0] ROT_BACK270  = 3'd3;
    localparam logic [2:0] ROT_FRONT270 = 3'd4;

    // Input item kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic is_read;
        logic not_ready;
        logic last;
    } cmd_flags_t;

    localparam int FLAGS_W = $bits(cmd_flags_t);

endpackage

### src/nv21r_if.sv
// Channel interfaces of the NV21 frame rotator: input items, results, configuration.
// Depends on nv21r_pkg.

interface nv21r_in_if import nv21r_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] pixel_byte;

    modport source (output valid, output mode, output pixel_byte, input ready);
    modport sink (input valid, input mode, input pixel_byte, output ready);
endinterface

interface nv21r_out_if import nv21r_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_frame;
    logic       not_ready;

    modport source (output valid, output out_byte, output last_of_frame,
                    output not_ready, input ready);
    modport sink (input valid, input out_byte, input last_of_frame,
                  input not_ready, output ready);
endinterface

interface nv21r_cfg_if import nv21r_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/nv21r_queue.sv
// Short command queue between the front and back of the NV21 frame rotator.
// Depends on nv21r_pkg for the queue depth.
module nv21r_queue import nv21r_pkg::*; #(
    parameter int WIDTH = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        priority if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/nv21r_front.sv
// Front of the NV21 frame rotator: configuration registers, load and emit
// counters, rotated source address. Emits memory commands into the queue.
// Depends on nv21r_pkg and nv21r_if.
module nv21r_front import nv21r_pkg::*; #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480,
    parameter int CW         = 19,
    parameter int AW         = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    nv21r_in_if.sink         pin,
    nv21r_cfg_if.sink        cfg,
    output logic             push_valid,
    input  logic             push_ready,
    output cmd_flags_t       push_flags,
    output logic [AW-1:0]    push_addr,
    output logic [7:0]       push_data
);

    // Configuration
    logic [9:0] width_reg, width_next;
    logic [8:0] height_reg, height_next;
    logic [2:0] rotation_reg, rotation_next;
    logic       settle_reg;
    logic       cfg_wr, cfg_hit;

    // Effective sizes, refreshed every cycle from the registers
    logic [9:0]    w_eff;
    logic [8:0]    h_eff;
    logic [18:0]   wh_full;
    logic [CW-1:0] wh_c, size_c;
    logic [9:0]    w_reg;
    logic [8:0]    h_reg;
    logic [7:0]    hh_reg;
    logic [CW-1:0] wh_reg, size_reg, rc_reg;

    // Frame counters
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic [CW-1:0] emit_cnt_reg, emit_cnt_next;
    logic [9:0]    ocol_reg, ocol_next;
    logic [8:0]    orow_reg, orow_next;
    logic          full_reg, full_next;

    // Address path
    logic          in_acc, is_fetch, luma, bsel, last;
    logic [CW-1:0] load_inc, emit_inc, base, addr_full;
    logic [9:0]    col_sel, orow_inc;
    logic [8:0]    row_sel;
    logic [18:0]   prod;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_wr && (cfg.index == REG_FRAME_WIDTH
                                  || cfg.index == REG_FRAME_HEIGHT
                                  || cfg.index == REG_ROTATION);

    // Hold input in the cycle after a register write while sizes settle
    assign pin.ready = !settle_reg && push_ready;
    assign in_acc    = pin.valid && pin.ready;
    assign is_fetch  = (pin.mode == MODE_FETCH);

    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        rotation_next = rotation_reg;
        if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  width_next    = cfg.data[9:0];
                REG_FRAME_HEIGHT: height_next   = cfg.data[8:0];
                REG_ROTATION:     rotation_next = cfg.data[2:0];
                default:          ;
            endcase
        end
    end

    // Clamp to the maximum, round down to even, never below 2
    always_comb
    begin
        w_eff = width_reg;
        if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = 10'(MAX_WIDTH);
        end
        w_eff[0] = 1'b0;
        if (w_eff < 10'd2)
        begin
            w_eff = 10'd2;
        end
        h_eff = height_reg;
        if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = 9'(MAX_HEIGHT);
        end
        h_eff[0] = 1'b0;
        if (h_eff < 9'd2)
        begin
            h_eff = 9'd2;
        end
        wh_full = 19'(w_eff) * 19'(h_eff);
        wh_c    = CW'(wh_full);
        size_c  = CW'({1'b0, wh_full} + {2'b00, wh_full[18:1]});
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_eff;
        h_reg    <= h_eff;
        hh_reg   <= h_eff[8:1];
        wh_reg   <= wh_c;
        size_reg <= size_c;
        rc_reg   <= size_c + wh_c - CW'(2);
    end

    // Source address of the current emit position
    assign luma     = (emit_cnt_reg < wh_reg);
    assign bsel     = emit_cnt_reg[0];
    assign emit_inc = emit_cnt_reg + CW'(1);
    assign load_inc = load_cnt_reg + CW'(1);
    assign last     = (emit_inc >= size_reg);
    assign orow_inc = {1'b0, orow_reg} + 10'd1;

    always_comb
    begin
        if (luma)
        begin
            col_sel = (rotation_reg == ROT_CW90) ? ocol_reg
                                                 : w_reg - 10'd1 - ocol_reg;
            row_sel = (rotation_reg == ROT_FRONT270) ? orow_reg
                                                     : h_reg - 9'd1 - orow_reg;
            base    = '0;
        end
        else
        begin
            // chroma moves as V/U pairs: bsel picks the byte within the pair
            col_sel = (rotation_reg == ROT_CW90)
                      ? {ocol_reg[8:0], bsel}
                      : w_reg - 10'd2 - {ocol_reg[8:0], 1'b0} + {9'd0, bsel};
            row_sel = (rotation_reg == ROT_FRONT270) ? orow_reg
                                                     : {1'b0, hh_reg} - 9'd1 - orow_reg;
            base    = wh_reg;
        end
        prod = 19'(row_sel) * 19'(w_reg);

        unique case (rotation_reg)
            ROT_180:
            begin
                if (luma)
                begin
                    addr_full = wh_reg - CW'(1) - emit_cnt_reg;
                end
                else
                begin
                    addr_full = rc_reg - {emit_cnt_reg[CW-1:1], 1'b0} + CW'(bsel);
                end
            end
            ROT_CW90, ROT_BACK270, ROT_FRONT270:
            begin
                addr_full = base + CW'(prod) + CW'(col_sel);
            end
            default:
            begin
                addr_full = emit_cnt_reg;
            end
        endcase
    end

    // Queue command
    always_comb
    begin
        push_valid = in_acc && (is_fetch || !full_reg);
        push_data  = pin.pixel_byte;
        if (!is_fetch)
        begin
            push_flags = '{is_read: 1'b0, not_ready: 1'b0, last: 1'b0};
            push_addr  = load_cnt_reg[AW-1:0];
        end
        else if (!full_reg)
        begin
            push_flags = '{is_read: 1'b1, not_ready: 1'b1, last: 1'b0};
            push_addr  = '0;
        end
        else
        begin
            push_flags = '{is_read: 1'b1, not_ready: 1'b0, last: last};
            push_addr  = addr_full[AW-1:0];
        end
    end

    // Counter update
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        ocol_next     = ocol_reg;
        orow_next     = orow_reg;
        full_next     = full_reg;
        priority if (cfg_hit)
        begin
            load_cnt_next = '0;
            emit_cnt_next = '0;
            ocol_next     = '0;
            orow_next     = '0;
            full_next     = 1'b0;
        end
        else if (in_acc && !is_fetch && !full_reg)
        begin
            load_cnt_next = load_inc;
            if (load_inc >= size_reg)
            begin
                full_next     = 1'b1;
                emit_cnt_next = '0;
                ocol_next     = '0;
                orow_next     = '0;
            end
        end
        else if (in_acc && is_fetch && full_reg)
        begin
            if (last)
            begin
                load_cnt_next = '0;
                emit_cnt_next = '0;
                ocol_next     = '0;
                orow_next     = '0;
                full_next     = 1'b0;
            end
            else
            begin
                emit_cnt_next = emit_inc;
                if (luma)
                begin
                    priority if (emit_inc == wh_reg)
                    begin
                        ocol_next = '0;
                        orow_next = '0;
                    end
                    else if (orow_inc >= {1'b0, h_reg})
                    begin
                        orow_next = '0;
                        ocol_next = ocol_reg + 10'd1;
                    end
                    else
                    begin
                        orow_next = orow_inc[8:0];
                    end
                end
                else if (bsel)
                begin
                    if (orow_inc >= {2'b00, hh_reg})
                    begin
                        orow_next = '0;
                        ocol_next = ocol_reg + 10'd1;
                    end
                    else
                    begin
                        orow_next = orow_inc[8:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= FRAME_WIDTH_RST;
            height_reg   <= FRAME_HEIGHT_RST;
            rotation_reg <= ROT_NONE;
            settle_reg   <= 1'b1;
            load_cnt_reg <= '0;
            emit_cnt_reg <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            rotation_reg <= rotation_next;
            settle_reg   <= cfg_wr;
            load_cnt_reg <= load_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            full_reg     <= full_next;
        end
    end

endmodule

### src/nv21r_back.sv
// Back of the NV21 frame rotator: frame store, read stage and result register.
// Depends on nv21r_pkg and nv21r_if.
module nv21r_back import nv21r_pkg::*; #(
    parameter int STORE_DEPTH = 460800,
    parameter int AW          = 19
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cmd_flags_t    cmd_flags,
    input  logic [AW-1:0] cmd_addr,
    input  logic [7:0]    cmd_data,
    nv21r_out_if.source   pout
);

    logic [7:0] store_mem [STORE_DEPTH];

    logic       stg_valid_reg, stg_valid_next;
    logic       stg_nr_reg, stg_last_reg;
    logic [7:0] rd_data_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg, out_nr_reg;

    logic out_take, out_free, stg_move, stg_free, pop, issue_rd, issue_wr;

    assign out_take  = out_valid_reg && pout.ready;
    assign out_free  = !out_valid_reg || out_take;
    assign stg_move  = stg_valid_reg && out_free;
    assign stg_free  = !stg_valid_reg || stg_move;
    // writes never wait; reads wait for room in the read stage
    assign pop       = cmd_valid && (!cmd_flags.is_read || stg_free);
    assign cmd_ready = !cmd_flags.is_read || stg_free;
    assign issue_rd  = pop && cmd_flags.is_read;
    assign issue_wr  = pop && !cmd_flags.is_read;

    assign pout.valid         = out_valid_reg;
    assign pout.out_byte      = out_byte_reg;
    assign pout.last_of_frame = out_last_reg;
    assign pout.not_ready     = out_nr_reg;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        out_valid_next = out_valid_reg;
        if (stg_move)
        begin
            stg_valid_next = 1'b0;
        end
        if (issue_rd)
        begin
            stg_valid_next = 1'b1;
        end
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (stg_move)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_wr)
        begin
            store_mem[cmd_addr] <= cmd_data;
        end
        if (issue_rd)
        begin
            rd_data_reg <= store_mem[cmd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_rd)
        begin
            stg_nr_reg   <= cmd_flags.not_ready;
            stg_last_reg <= cmd_flags.last;
        end
        if (stg_move)
        begin
            out_byte_reg <= stg_nr_reg ? 8'd0 : rd_data_reg;
            out_last_reg <= stg_last_reg;
            out_nr_reg   <= stg_nr_reg;
        end
    end

endmodule

### src/nv21_frame_rotator_top.sv
// Top level of the NV21 frame rotator: front, command queue and back.
// Depends on nv21r_pkg, nv21r_if, nv21r_queue, nv21r_front and nv21r_back.
//
//  Port       | Role   | Payload                          | Transaction
//  -----------+--------+----------------------------------+--------------------
//  pixel_in   | sink   | mode, pixel_byte                 | valid && ready
//  pixel_out  | source | out_byte, last_of_frame, not_ready | valid && ready
//  cfg        | sink   | index, data                      | valid && ready
//
//  One item per cycle: a load or fetch whenever the queue has room and no write settles.
//  A fetch result passes the queue, the store read stage and the result register.
//  The frame store is a single-port memory: one write or one read per cycle.
//  Each register write holds pixel_in in the following cycle while the frame sizes settle.
//  Reset clears counters, presets registers; the store is not cleared and needs no sweep.
//  A stalled pixel_out backs up through the read stage into the queue and then pixel_in.
module nv21_frame_rotator_top import nv21r_pkg::*; #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    nv21r_in_if.sink    pixel_in,
    nv21r_out_if.source pixel_out,
    nv21r_cfg_if.sink   cfg
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = $clog2(STORE_DEPTH + 1);
    localparam int QW          = FLAGS_W + AW + 8;

    logic          q_push_valid, q_push_ready;
    cmd_flags_t    push_flags;
    logic [AW-1:0] push_addr;
    logic [7:0]    push_data;
    logic          q_pop_valid, q_pop_ready;
    logic [QW-1:0] q_pop_data;
    cmd_flags_t    cmd_flags;
    logic [AW-1:0] cmd_addr;
    logic [7:0]    cmd_data;

    nv21r_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .AW         (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pin        (pixel_in),
        .cfg        (cfg),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_flags (push_flags),
        .push_addr  (push_addr),
        .push_data  (push_data)
    );

    nv21r_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  ({push_flags, push_addr, push_data}),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    assign {cmd_flags, cmd_addr, cmd_data} = q_pop_data;

    nv21r_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_pop_valid),
        .cmd_ready (q_pop_ready),
        .cmd_flags (cmd_flags),
        .cmd_addr  (cmd_addr),
        .cmd_data  (cmd_data),
        .pout      (pixel_out)
    );

`ifndef SYNTHESIS
    // The front only pushes on an accepted item, which needs room in the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid |-> q_push_ready)
        else $error("command pushed into a full queue");

    // A register write stalls the input for the next cycle
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> !pixel_in.ready)
        else $error("input taken while frame sizes settle");

    // A fetch without a full frame carries a zero byte and no end mark
    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_out.valid && pixel_out.not_ready
            |-> pixel_out.out_byte == 8'd0 && !pixel_out.last_of_frame)
        else $error("not_ready result with payload");
`endif

endmodule

### sim/nv21_frame_rotator_top_tb.sv
// Self-checking testbench for nv21_frame_rotator_top: loads NV21 frames, fetches them
// rotated and checks every result byte against a frame-rotation tracker held here.
// Depends on nv21r_pkg, nv21r_if and the rotator RTL.
module nv21_frame_rotator_top_tb import nv21r_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 640;
    localparam int MAX_H         = 480;
    localparam int STORE_DEPTH   = MAX_W * MAX_H * 3 / 2;
    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int ITEM_BUDGET   = 650;

    // register index outside the list, and rotation codes that pass through
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [2:0] ROT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ROT_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [7:0] pix;
        logic       last_flag;
        logic       not_ready;
    } fetch_result_t;

    class rotated_frame_tracker;
        logic [7:0]    frame_mem [0:STORE_DEPTH-1];
        int unsigned   width_reg;
        int unsigned   height_reg;
        logic [2:0]    rot_reg;
        int unsigned   loaded;
        int unsigned   emitted;
        int unsigned   col;
        int unsigned   row;
        bit            full;
        fetch_result_t expected_bytes [$];
        int unsigned   mismatches;

        function new();
            width_reg  = 32'(FRAME_WIDTH_RST);
            height_reg = 32'(FRAME_HEIGHT_RST);
            rot_reg    = ROT_NONE;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            loaded  = 0;
            emitted = 0;
            col     = 0;
            row     = 0;
            full    = 0;
        endfunction

        function int unsigned clamp_even(int unsigned v, int unsigned maxv);
            int unsigned r;
            r = (v > maxv) ? maxv : v;
            r = r & ~32'd1;
            return (r < 2) ? 2 : r;
        endfunction

        function int unsigned frame_bytes();
            return clamp_even(width_reg, MAX_W) * clamp_even(height_reg, MAX_H) * 3 / 2;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == REG_FRAME_WIDTH)
                width_reg = 32'(d);
            else if (idx == REG_FRAME_HEIGHT)
                height_reg = 32'(d[8:0]);
            else if (idx == REG_ROTATION)
                rot_reg = d[2:0];
            else
                return;
            // any write to a known register drops the frame in flight
            restart();
        endfunction

        function int unsigned source_index(int unsigned w, int unsigned h);
            int unsigned wh;
            int unsigned b;
            int unsigned c;
            int unsigned r;
            wh = w * h;
            b  = emitted & 1;
            if (rot_reg == ROT_180)
            begin
                if (emitted < wh)
                    return wh - 1 - emitted;
                return wh + 2 * (wh / 4 - 1 - ((emitted - wh) >> 1)) + b;
            end
            if (rot_reg < ROT_CW90 || rot_reg > ROT_FRONT270)
                return emitted;
            if (emitted < wh)
            begin
                c = (rot_reg == ROT_CW90) ? col : w - 1 - col;
                r = (rot_reg == ROT_FRONT270) ? row : h - 1 - row;
                return r * w + c;
            end
            // chroma moves as V/U pairs
            c = (rot_reg == ROT_CW90) ? 2 * col + b : w - 2 - 2 * col + b;
            r = (rot_reg == ROT_FRONT270) ? row : h / 2 - 1 - row;
            return wh + r * w + c;
        endfunction

        function void step_position(int unsigned w, int unsigned h);
            int unsigned wh;
            wh = w * h;
            if (emitted < wh)
            begin
                if (emitted + 1 == wh)
                begin
                    col = 0;
                    row = 0;
                end
                else if (++row >= h)
                begin
                    row = 0;
                    col++;
                end
            end
            else if (emitted & 1)
            begin
                if (++row >= h / 2)
                begin
                    row = 0;
                    col++;
                end
            end
            emitted++;
        endfunction

        function void take_item(logic m, logic [7:0] b);
            int unsigned   w;
            int unsigned   h;
            int unsigned   sz;
            fetch_result_t res;
            w  = clamp_even(width_reg, MAX_W);
            h  = clamp_even(height_reg, MAX_H);
            sz = w * h * 3 / 2;
            if (m == MODE_LOAD)
            begin
                if (!full)
                begin
                    if (loaded < sz)
                        frame_mem[loaded] = b;
                    loaded++;
                    if (loaded >= sz)
                    begin
                        full    = 1;
                        emitted = 0;
                        col     = 0;
                        row     = 0;
                    end
                end
                return;
            end
            res = '{8'h00, 1'b0, 1'b1};
            if (full)
            begin
                res.pix       = frame_mem[source_index(w, h)];
                res.last_flag = (emitted + 1 >= sz);
                res.not_ready = 1'b0;
                if (res.last_flag)
                    restart();
                else
                    step_position(w, h);
            end
            expected_bytes.push_back(res);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_byte(logic [7:0] pix, logic last_flag, logic not_ready);
            fetch_result_t want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("result %02h with no fetch outstanding", pix));
                return;
            end
            want = expected_bytes.pop_front();
            if (pix !== want.pix)
                report($sformatf("out_byte %02h, want %02h", pix, want.pix));
            if (last_flag !== want.last_flag)
                report($sformatf("last_of_frame %b, want %b", last_flag, want.last_flag));
            if (not_ready !== want.not_ready)
                report($sformatf("not_ready %b, want %b", not_ready, want.not_ready));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    nv21r_in_if  pix_in ();
    nv21r_out_if pix_out ();
    nv21r_cfg_if cfg_ch ();

    nv21_frame_rotator_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_in),
        .pixel_out (pix_out),
        .cfg       (cfg_ch)
    );

    rotated_frame_tracker tracker = new();

    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned item_count   = 0;
    int unsigned quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    always @(negedge clk)
    begin
        pix_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    // sample transactions and guard against a hung handshake
    always @(posedge clk)
    begin : monitor
        logic moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                tracker.check_byte(pix_out.out_byte, pix_out.last_of_frame,
                                   pix_out.not_ready);
                moved = 1'b1;
            end
            if (pix_in.valid && pix_in.ready)
            begin
                tracker.take_item(pix_in.mode, pix_in.pixel_byte);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                tracker.apply_register(cfg_ch.index, cfg_ch.data);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("nv21_frame_rotator_top_tb failed");
            $finish;
        end
    end

    // call at a falling edge; returns at the falling edge after the transaction
    task automatic push_item(logic m, logic [7:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.mode       <= m;
        pix_in.pixel_byte <= b;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        pix_in.valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending() != 0);
    endtask

    // idle the block: no result owed and no load still in the pipe
    task automatic quiesce();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_bytes(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
            begin
                push_item(MODE_FETCH, 8'($urandom_range(255)));
                item_count++;
            end
            push_item(MODE_LOAD, 8'($urandom_range(255)));
            item_count++;
        end
    endtask

    task automatic fetch_bytes(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(999) < 15)
                hold_until_drained();
            push_item(MODE_FETCH, 8'($urandom_range(255)));
            item_count++;
        end
    endtask

    function automatic logic [9:0] small_dim();
        if ($urandom_range(99) < 80)
            return 10'(2 * $urandom_range(4, 1));
        return 10'($urandom_range(9, 0));
    endfunction

    task automatic configure();
        logic [9:0] wd;
        logic [9:0] hd;
        logic [2:0] rot;
        logic       hi;
        logic [6:0] junk;
        quiesce();
        wd = small_dim();
        hd = small_dim();
        if ($urandom_range(99) < 75)
            rot = 3'($urandom_range(ROT_FRONT270, ROT_NONE));
        else
            rot = 3'($urandom_range(ROT_SPARE_LAST, ROT_SPARE_FIRST));
        hi   = 1'($urandom_range(1));
        junk = 7'($urandom_range(127));
        if ($urandom_range(99) < 20)
            write_reg(REG_SPARE, 10'($urandom_range(1023)));
        write_reg(REG_FRAME_WIDTH, wd);
        write_reg(REG_FRAME_HEIGHT, {hi, hd[8:0]});
        write_reg(REG_ROTATION, {junk, rot});
    endtask

    task automatic run_frame(bit may_break);
        int unsigned sz;
        int unsigned passes;
        sz = tracker.frame_bytes();
        if (may_break && $urandom_range(99) < 15)
        begin
            // abandon the frame part way; the next register write drops it
            if ($urandom_range(1))
            begin
                load_bytes($urandom_range(sz - 1, 0));
            end
            else
            begin
                load_bytes(sz);
                fetch_bytes($urandom_range(sz - 1, 1));
            end
            return;
        end
        passes = ($urandom_range(99) < 40) ? 2 : 1;
        repeat (passes)
        begin
            load_bytes(sz);
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(3, 1)) push_item(MODE_LOAD, 8'($urandom_range(255)));
            fetch_bytes(sz);
        end
    endtask

    initial
    begin : stimulus
        rst_n             = 1'b0;
        pix_in.valid      = 1'b0;
        pix_in.mode       = MODE_LOAD;
        pix_in.pixel_byte = 8'h00;
        pix_out.ready     = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_FRAME_WIDTH;
        cfg_ch.data       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fetch with nothing loaded, then odd and zero sizes that round to 2x2
        push_item(MODE_FETCH, 8'h00);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 10'd3);
        write_reg(REG_FRAME_HEIGHT, 10'd0);
        write_reg(REG_ROTATION, {7'd0, ROT_CW90});
        push_item(MODE_LOAD, 8'h00);
        push_item(MODE_LOAD, 8'hFF);
        push_item(MODE_LOAD, 8'($urandom_range(255)));
        // a write to an unknown index keeps the partial frame
        quiesce();
        write_reg(REG_SPARE, 10'h3FF);
        repeat (3) push_item(MODE_LOAD, 8'($urandom_range(255)));
        // frame is waiting: this load is dropped
        push_item(MODE_LOAD, 8'hA5);
        fetch_bytes(3);
        hold_until_drained();
        fetch_bytes(3);
        // rewriting the same rotation discards a partial frame
        repeat (2) push_item(MODE_LOAD, 8'($urandom_range(255)));
        quiesce();
        write_reg(REG_ROTATION, {7'd0, ROT_CW90});
        load_bytes(6);
        fetch_bytes(6);

        item_count = 0;
        for (int p = 0; p < 4; p++)
        begin
            gap_pct   = (p == 1) ? 58 : (p == 3) ? 36 : 0;
            stall_pct = (p == 2) ? 58 : (p == 3) ? 36 : 0;
            while (item_count < (p + 1) * ITEM_BUDGET / 4)
            begin
                configure();
                run_frame(1'b1);
            end
        end

        quiesce();
        if (tracker.mismatches == 0)
            $display("nv21_frame_rotator_top_tb passed");
        else
            $display("nv21_frame_rotator_top_tb failed");
        $finish;
    end
endmodule

### sim.f
src/nv21r_pkg.sv
src/nv21r_if.sv
src/nv21r_queue.sv
src/nv21r_front.sv
src/nv21r_back.sv
src/nv21_frame_rotator_top.sv
sim/nv21_frame_rotator_top_tb.sv
